// ===== rtl/core/osu_pkg.sv =====
// Shared types and constants of the operand stack unit.
`default_nettype none
package osu_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int WORD_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int NEED_W      = CNT_W + 1;
	localparam int OP_W        = 4;
	localparam int LEN_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int DATA_W      = 32;
	localparam int LIMIT_W     = 11;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
	localparam logic [CNT_W-1:0]   CK_MIN_FREE = CNT_W'(8);

	localparam logic [LEN_W-1:0] LEN_ONE_BYTE   = 4'd1;
	localparam logic [LEN_W-1:0] LEN_CKHEIGHT   = 4'd5;
	localparam logic [LEN_W-1:0] LEN_WIDE_ONE   = 4'd6;
	localparam logic [LEN_W-1:0] LEN_WIDE_TWO   = 4'd10;
	localparam logic [LEN_W-1:0] LEN_NARROW_TWO = 4'd3;
	localparam logic [LEN_W-1:0] LEN_NARROW_ONE = 4'd2;
	localparam logic [LEN_W-1:0] LEN_NONE       = 4'd0;

	localparam logic [PADDR_W-3:0] REG_STACK_LIMIT = '0;

	typedef enum logic [OP_W-1:0] {
		OP_DUP          = 4'd0,
		OP_DUP2         = 4'd1,
		OP_DUP_N        = 4'd2,
		OP_PICK         = 4'd3,
		OP_POP          = 4'd4,
		OP_POP2         = 4'd5,
		OP_POP_N        = 4'd6,
		OP_SQUASH       = 4'd7,
		OP_CKHEIGHT     = 4'd8,
		OP_CKHEIGHT_N   = 4'd9,
		OP_SET_FRAME    = 4'd10,
		OP_PUSH         = 4'd11
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 2'd0,
		STS_OVERFLOW = 2'd1,
		STS_FAULT    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVAL,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_TOP_RD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [WORD_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/osu_if.sv =====
// Handshake channels of the operand stack unit.
`default_nettype none
interface osu_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [osu_pkg::OP_W-1:0]             operation;
	logic [osu_pkg::CNT_W-1:0]            count_n;
	logic [osu_pkg::CNT_W-1:0]            count_m;
	logic                                 wide;
	logic [osu_pkg::DATA_W-1:0]           push_value;

	modport source(output valid, operation, count_n, count_m, wide, push_value, input ready);
	modport sink(input valid, operation, count_n, count_m, wide, push_value, output ready);
endinterface

interface osu_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [osu_pkg::STATUS_W-1:0]         status;
	logic [osu_pkg::LEN_W-1:0]            pc_advance;
	logic [osu_pkg::CNT_W-1:0]            stack_height;
	logic [osu_pkg::CNT_W-1:0]            frame_index;
	logic [osu_pkg::DATA_W-1:0]           top_word;

	modport source(output valid, status, pc_advance, stack_height, frame_index, top_word,
		input ready);
	modport sink(input valid, status, pc_advance, stack_height, frame_index, top_word,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/osu_mem.sv =====
// Stack word memory: one write port, one registered read port.
`default_nettype none
module osu_mem (
	input  wire logic                           clk,
	input  wire osu_pkg::mem_req_t              req,
	output logic [osu_pkg::WORD_WIDTH-1:0]      rdata
);
	import osu_pkg::*;

	logic [WORD_WIDTH-1:0] words_q [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			words_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= words_q[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/osu_ctrl.sv =====
// Opcode sequencer: bounds checks, index registers and word copy loop.
`default_nettype none
module osu_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [osu_pkg::LIMIT_W-1:0]    stack_limit,
	osu_in_if.sink                              cmd,
	osu_out_if.source                           rsp,
	output osu_pkg::mem_req_t                   mem_req,
	input  wire logic [osu_pkg::WORD_WIDTH-1:0] mem_rdata
);
	import osu_pkg::*;

	state_t state_q, state_d;

	op_t                   op_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      m_q;
	logic                  wide_q;
	logic [WORD_WIDTH-1:0] pv_q;

	logic [NEED_W-1:0]     need_q;
	logic [CNT_W-1:0]      grow_q;
	logic [CNT_W-1:0]      free_q;
	logic [LEN_W-1:0]      len_q;
	status_t               pre_q;
	status_t               status_q;

	logic [CNT_W-1:0]      top_q;
	logic [CNT_W-1:0]      frame_q;
	logic [ADDR_W-1:0]     src_q;
	logic [ADDR_W-1:0]     dst_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [CNT_W-1:0]      out_height_q;
	logic [CNT_W-1:0]      out_frame_q;
	logic [DATA_W-1:0]     out_word_q;

	logic [NEED_W-1:0]     need_c;
	logic [CNT_W-1:0]      grow_c;
	logic [LEN_W-1:0]      len_c;
	status_t               pre_c;
	logic [CNT_W-1:0]      lim_c;
	logic [CNT_W-1:0]      free_c;
	logic [LEN_W-1:0]      one_len_c;
	status_t               status_c;
	logic [CNT_W-1:0]      h_minus_need;
	logic [CNT_W-1:0]      h_minus_n;
	logic [CNT_W-1:0]      h_minus_m;
	logic [CNT_W-1:0]      h_plus_grow;
	logic [CNT_W-1:0]      top_dec;
	logic                  load_out;

	// Decode and free space, from the captured opcode.
	always_comb begin
		lim_c     = (stack_limit < CNT_W'(STACK_DEPTH)) ? stack_limit : CNT_W'(STACK_DEPTH);
		free_c    = (top_q < lim_c) ? (lim_c - top_q) : '0;
		one_len_c = wide_q ? LEN_WIDE_ONE : LEN_NARROW_ONE;
		need_c    = '0;
		grow_c    = '0;
		len_c     = LEN_ONE_BYTE;
		pre_c     = STS_OK;
		unique case (op_q)
			OP_DUP: begin
				need_c = NEED_W'(1);
				grow_c = CNT_W'(1);
			end
			OP_DUP2: begin
				need_c = NEED_W'(2);
				grow_c = CNT_W'(2);
			end
			OP_DUP_N: begin
				need_c = {1'b0, n_q};
				grow_c = n_q;
				len_c  = one_len_c;
			end
			OP_PICK: begin
				need_c = {1'b0, n_q} + NEED_W'(1);
				grow_c = CNT_W'(1);
				len_c  = one_len_c;
			end
			OP_POP: need_c = NEED_W'(1);
			OP_POP2: need_c = NEED_W'(2);
			OP_POP_N: begin
				need_c = {1'b0, n_q};
				len_c  = one_len_c;
			end
			OP_SQUASH: begin
				need_c = {1'b0, n_q} + {1'b0, m_q};
				len_c  = wide_q ? LEN_WIDE_TWO : LEN_NARROW_TWO;
			end
			OP_CKHEIGHT: begin
				len_c = LEN_CKHEIGHT;
				if (free_c < CK_MIN_FREE) begin
					pre_c = STS_OVERFLOW;
				end
			end
			OP_CKHEIGHT_N: begin
				len_c = LEN_CKHEIGHT;
				if (free_c < n_q) begin
					pre_c = STS_OVERFLOW;
				end
			end
			OP_SET_FRAME: begin
				need_c = {1'b0, n_q};
				len_c  = one_len_c;
			end
			OP_PUSH: grow_c = CNT_W'(1);
			default: pre_c = STS_FAULT;
		endcase
	end

	// Final status and new indexes.
	always_comb begin
		if (pre_q != STS_OK) begin
			status_c = pre_q;
		end else if ({1'b0, top_q} < need_q) begin
			status_c = STS_FAULT;
		end else if (grow_q > free_q) begin
			status_c = STS_OVERFLOW;
		end else begin
			status_c = STS_OK;
		end
		h_minus_need = top_q - need_q[CNT_W-1:0];
		h_minus_n    = top_q - n_q;
		h_minus_m    = top_q - m_q;
		h_plus_grow  = top_q + grow_q;
		top_dec      = top_q - CNT_W'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = ST_EVAL;
			ST_EVAL: state_d = ST_COPY_RD;
			ST_COPY_RD: state_d = (cnt_q == '0) ? ST_TOP_RD : ST_COPY_WR;
			ST_COPY_WR: state_d = ST_COPY_RD;
			ST_TOP_RD: state_d = ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
		mem_req   = '{we: 1'b0, waddr: dst_q, wdata: mem_rdata, re: 1'b0, raddr: src_q};
		unique case (state_q)
			ST_EVAL: begin
				mem_req.we    = (status_c == STS_OK) && (op_q == OP_PUSH);
				mem_req.waddr = top_q[ADDR_W-1:0];
				mem_req.wdata = pv_q;
			end
			ST_COPY_RD: mem_req.re = (cnt_q != '0);
			ST_COPY_WR: mem_req.we = 1'b1;
			ST_TOP_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = top_dec[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			frame_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EVAL: begin
					if (status_c == STS_OK) begin
						unique case (op_q)
							OP_DUP, OP_DUP2, OP_DUP_N: begin
								src_q <= h_minus_need[ADDR_W-1:0];
								dst_q <= top_q[ADDR_W-1:0];
								cnt_q <= grow_q;
								top_q <= h_plus_grow;
							end
							OP_PICK: begin
								src_q <= h_minus_need[ADDR_W-1:0];
								dst_q <= top_q[ADDR_W-1:0];
								cnt_q <= CNT_W'(1);
								top_q <= h_plus_grow;
							end
							OP_POP, OP_POP2, OP_POP_N: top_q <= h_minus_need;
							OP_SQUASH: begin
								src_q <= h_minus_n[ADDR_W-1:0];
								dst_q <= h_minus_need[ADDR_W-1:0];
								cnt_q <= n_q;
								top_q <= h_minus_m;
							end
							OP_SET_FRAME: frame_q <= h_minus_n;
							OP_PUSH: top_q <= h_plus_grow;
							default: begin
							end
						endcase
					end
				end
				ST_COPY_WR: begin
					src_q <= src_q + ADDR_W'(1);
					dst_q <= dst_q + ADDR_W'(1);
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q   <= op_t'(cmd.operation);
			n_q    <= cmd.count_n;
			m_q    <= cmd.count_m;
			wide_q <= cmd.wide;
			pv_q   <= cmd.push_value[WORD_WIDTH-1:0];
		end
		if (state_q == ST_CHECK) begin
			need_q <= need_c;
			grow_q <= grow_c;
			free_q <= free_c;
			len_q  <= len_c;
			pre_q  <= pre_c;
		end
		if (state_q == ST_EVAL) begin
			status_q <= status_c;
		end
		if (load_out) begin
			out_status_q <= status_q;
			out_len_q    <= (status_q == STS_OK) ? len_q : LEN_NONE;
			out_height_q <= top_q;
			out_frame_q  <= frame_q;
			out_word_q   <= (top_q == '0) ? '0 : DATA_W'(mem_rdata);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.pc_advance   = out_len_q;
	assign rsp.stack_height = out_height_q;
	assign rsp.frame_index  = out_frame_q;
	assign rsp.top_word     = out_word_q;

endmodule
`default_nettype wire

// ===== rtl/core/operand_stack_unit.sv =====
// Operand stack unit top level: configuration register, sequencer and word memory.
//
// Usage: cmd carries one stack opcode per transaction (operation, count_n,
// count_m, wide, push_value); rsp returns exactly one result per opcode
// (status, pc_advance, stack_height, frame_index, top_word). The APB port
// holds stack_limit at byte address 0; write it only while the unit is idle.
// Timing: one opcode is worked at a time; cmd.ready is high only when the
// sequencer is idle. An accepted opcode passes the check and evaluate states,
// then a read state and a write state per word copied by dup, dup2, dup_n,
// pick and squash, since each copy shares the single read and write port of
// the word memory; then the top word is read and the result is loaded into rsp,
// raising rsp.valid. The next opcode is accepted in the cycle after the result is loaded.
// Pops, checks, set_frame and push copy nothing. A failing opcode copies nothing either.
// Reset: height, frame base and control clear at once; stack_limit returns
// to 1024. The word memory is not cleared; only words below the top are used.
// Stall: a result waits in the rsp register while rsp.ready is low; the next
// opcode is accepted and worked meanwhile, and its result waits for the slot.
`default_nettype none
module operand_stack_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [osu_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [osu_pkg::PDATA_W-1:0]   pwdata,
	output logic [osu_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	osu_in_if.sink                             cmd,
	osu_out_if.source                          rsp
);
	import osu_pkg::*;

	logic [LIMIT_W-1:0]    stack_limit_q;
	mem_req_t              mem_req;
	logic [WORD_WIDTH-1:0] mem_rdata;
	logic                  reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_STACK_LIMIT);
	assign prdata  = reg_hit ? PDATA_W'(stack_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			stack_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	osu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.stack_limit (stack_limit_q),
		.cmd         (cmd),
		.rsp         (rsp),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	osu_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire
